@@ hw/rtl/variable_partition_allocator_assert.svh @@
// assertion macros for the partition allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define VPA_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("vpa assertion failed");

// next-cycle implication
`define VPA_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("vpa assertion failed");

`endif

@@ hw/rtl/vpa_pkg.sv @@
package vpa_pkg;

  localparam int SEGMENTS_DEF   = 32;
  localparam int ADDR_WIDTH_DEF = 20;
  localparam int MSIZE_W        = 21;
  localparam int EXAM_W         = 6;
  localparam logic [MSIZE_W-1:0] MSIZE_RESET = 21'd65536;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE    = 3'd0;
  localparam op_t OP_INIT    = 3'd1;
  localparam op_t OP_SETUSED = 3'd2;
  localparam op_t OP_INSERT  = 3'd3;
  localparam op_t OP_DROP    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_MOD   = 2'd2;

  localparam logic REG_MSIZE  = 1'b0;
  localparam logic REG_POLICY = 1'b1;

  // zero acts as one, oversize acts as the whole address space
  function automatic logic [32:0] clamp_size(input logic [MSIZE_W-1:0] v, input int aw);
    logic [32:0] t;
    logic [32:0] top;
    t = 33'(v);
    top = 33'(1) << aw;
    if (t == 33'd0) t = 33'd1;
    if (t > top) t = top;
    return t;
  endfunction

endpackage

@@ hw/rtl/vpa_cell.sv @@
module vpa_cell #(
  parameter int ME = 0,
  parameter int AW = vpa_pkg::ADDR_WIDTH_DEF,
  parameter int CW = 6,
  parameter logic [AW:0] RESET_LEN = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  vpa_pkg::op_t  op,
  input  logic [CW-1:0] op_idx,
  input  logic [AW:0]   a_len,
  input  logic [AW-1:0] b_base,
  input  logic [AW:0]   b_len,
  input  logic          flag,
  input  logic [AW-1:0] left_base,
  input  logic [AW:0]   left_len,
  input  logic          left_used,
  input  logic [AW-1:0] right_base,
  input  logic [AW:0]   right_len,
  input  logic          right_used,
  output logic [AW-1:0] base,
  output logic [AW:0]   len,
  output logic          used
);

  logic [CW:0] me;
  logic [CW:0] idx;
  assign me  = (CW+1)'(ME);
  assign idx = {1'b0, op_idx};

  // segment entry, shifted along the chain on insert and drop
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      len  <= (ME == 0) ? RESET_LEN : '0;
      used <= 1'b0;
    end else begin
      case (op)
        vpa_pkg::OP_INIT: begin
          base <= '0;
          len  <= (ME == 0) ? a_len : '0;
          used <= 1'b0;
        end
        vpa_pkg::OP_SETUSED: begin
          if (me == idx) used <= flag;
        end
        vpa_pkg::OP_INSERT: begin
          if (me == idx) begin
            len <= a_len;
          end else if (me == idx + 1'b1) begin
            base <= b_base;
            len  <= b_len;
            used <= 1'b1;
          end else if (me > idx + 1'b1) begin
            base <= left_base;
            len  <= left_len;
            used <= left_used;
          end
        end
        vpa_pkg::OP_DROP: begin
          if (me + 1'b1 == idx) begin
            len <= len + right_len;
          end else if (me >= idx) begin
            base <= right_base;
            len  <= right_len;
            used <= right_used;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/variable_partition_allocator.sv @@
// sequence: a zero request goes straight to done; an allocation scans the entries, or under
//   the modulo policy first probes the remembered hole, then carves a fitting hole; a free
//   searches for the block, then merges it with a free left and a free right neighbour
// requests: one at a time, the next start is taken the cycle after done
// results are strobed on done for one cycle and cannot be stalled
// reset: one free segment of 65536 units, first fit, remembered hole at entry 0
module variable_partition_allocator #(
  parameter int SEGMENTS   = vpa_pkg::SEGMENTS_DEF,
  parameter int ADDR_WIDTH = vpa_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [ADDR_WIDTH:0]   request_size,
  input  logic [ADDR_WIDTH-1:0] block_base,
  output logic                  done,
  output logic [1:0]            status,
  output logic [ADDR_WIDTH-1:0] granted_base,
  output logic [vpa_pkg::EXAM_W-1:0] entries_examined,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = ADDR_WIDTH;
  localparam int LW = AW + 1;
  localparam int IW = $clog2(SEGMENTS);
  localparam int CW = $clog2(SEGMENTS + 1);
  localparam int EW = vpa_pkg::EXAM_W;
  localparam logic [LW-1:0] RESET_LEN =
    LW'(vpa_pkg::clamp_size(vpa_pkg::MSIZE_RESET, AW));
  localparam logic [EW-1:0] EXAM_SAT = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CARVE = 3'd3;
  localparam logic [2:0] S_FOUND = 3'd4;
  localparam logic [2:0] S_ML    = 3'd5;
  localparam logic [2:0] S_MR    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state;
  logic          req_mode;
  logic [LW-1:0] req_size;
  logic [AW-1:0] req_blk;
  logic [CW-1:0] idx;
  logic [IW-1:0] hole;
  logic [LW-1:0] hole_len;
  logic [AW-1:0] hole_base;
  logic [IW-1:0] best_idx;
  logic [LW-1:0] best_len;
  logic [AW-1:0] best_base;
  logic          best_found;
  logic [IW-1:0] fidx;
  logic [CW-1:0] count;
  logic [IW-1:0] lh;
  logic          lhv;
  logic [vpa_pkg::MSIZE_W-1:0] msize;
  logic [1:0]    pol;

  // cell chain outputs
  logic [AW-1:0] c_base [SEGMENTS];
  logic [LW-1:0] c_len  [SEGMENTS];
  logic          c_used [SEGMENTS];

  vpa_pkg::op_t  op;
  logic [CW-1:0] op_idx;
  logic [LW-1:0] a_len;
  logic [AW-1:0] b_base;
  logic [LW-1:0] b_len;
  logic          flag;

  logic [IW-1:0] rd_idx;
  logic [AW-1:0] rd_base;
  logic [LW-1:0] rd_len;
  logic          rd_used;

  logic          cfg_wr;
  logic          pol_mod;
  logic          pol_worst;
  logic          ml_merge;
  logic          mr_merge;
  logic [CW:0]   fidx_p1;
  logic [LW-1:0] left_over;
  logic [15:0]   scan_tot;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);

  assign prdata = (paddr[2] == vpa_pkg::REG_POLICY) ? {30'b0, pol} : 32'(msize);

  assign pol_mod   = (pol == vpa_pkg::POL_MOD);
  assign pol_worst = (pol == vpa_pkg::POL_WORST) | pol_mod;

  // read port into the chain
  always_comb begin
    case (state)
      S_PROBE: rd_idx = lh;
      S_SCAN:  rd_idx = idx[IW-1:0];
      S_ML:    rd_idx = fidx - 1'b1;
      S_MR:    rd_idx = fidx + 1'b1;
      default: rd_idx = '0;
    endcase
  end
  assign rd_base = c_base[rd_idx];
  assign rd_len  = c_len[rd_idx];
  assign rd_used = c_used[rd_idx];

  assign fidx_p1   = (CW+1)'(fidx) + 1'b1;
  assign ml_merge  = (fidx != '0) && !rd_used;
  assign mr_merge  = (fidx_p1 < (CW+1)'(count)) && !rd_used;
  assign left_over = hole_len - req_size;
  assign scan_tot  = 16'(count) + 16'(pol_mod);

  // command broadcast to the cells
  always_comb begin
    op     = vpa_pkg::OP_NONE;
    op_idx = '0;
    a_len  = left_over;
    b_base = hole_base + AW'(left_over);
    b_len  = req_size;
    flag   = 1'b0;
    if (cfg_wr && paddr[2] == vpa_pkg::REG_MSIZE) begin
      op    = vpa_pkg::OP_INIT;
      a_len = LW'(vpa_pkg::clamp_size(pwdata[vpa_pkg::MSIZE_W-1:0], AW));
    end else begin
      case (state)
        S_CARVE: begin
          op_idx = CW'(hole);
          if (hole_len == req_size) begin
            op   = vpa_pkg::OP_SETUSED;
            flag = 1'b1;
          end else if (count != CW'(SEGMENTS)) begin
            op = vpa_pkg::OP_INSERT;
          end
        end
        S_FOUND: begin
          op     = vpa_pkg::OP_SETUSED;
          op_idx = CW'(fidx);
        end
        S_ML: begin
          op_idx = CW'(fidx);
          if (ml_merge) op = vpa_pkg::OP_DROP;
        end
        S_MR: begin
          op_idx = fidx_p1[CW-1:0];
          if (mr_merge) op = vpa_pkg::OP_DROP;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(1);
      lh    <= '0;
      lhv   <= 1'b1;
      msize <= vpa_pkg::MSIZE_RESET;
      pol   <= vpa_pkg::POL_FIRST;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == vpa_pkg::REG_MSIZE) begin
          msize <= pwdata[vpa_pkg::MSIZE_W-1:0];
          count <= CW'(1);
          lh    <= '0;
          lhv   <= 1'b1;
        end else begin
          pol <= pwdata[1:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req_mode         <= mode;
            req_size         <= request_size;
            req_blk          <= block_base;
            idx              <= '0;
            best_found       <= 1'b0;
            entries_examined <= '0;
            granted_base     <= '0;
            status           <= vpa_pkg::ST_NO_FIT;
            if (mode) begin
              state <= S_SCAN;
            end else if (request_size == '0) begin
              state <= S_DONE;
            end else if (pol_mod && lhv && (CW'(lh) < count)) begin
              state <= S_PROBE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_PROBE: begin
          if (!rd_used && rd_len >= req_size) begin
            entries_examined <= EW'(1);
            hole      <= lh;
            hole_len  <= rd_len;
            hole_base <= rd_base;
            state     <= S_CARVE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (req_mode) begin
            if (idx < count) begin
              if (rd_used && rd_base == req_blk) begin
                fidx  <= idx[IW-1:0];
                state <= S_FOUND;
              end
              idx <= idx + 1'b1;
            end else begin
              status <= vpa_pkg::ST_NOT_FOUND;
              state  <= S_DONE;
            end
          end else if (pol_worst) begin
            if (idx < count) begin
              if (!rd_used && (!best_found || rd_len > best_len)) begin
                best_found <= 1'b1;
                best_idx   <= idx[IW-1:0];
                best_len   <= rd_len;
                best_base  <= rd_base;
              end
              idx <= idx + 1'b1;
            end else begin
              entries_examined <= (scan_tot > 16'(EXAM_SAT)) ? EXAM_SAT : scan_tot[EW-1:0];
              if (best_found) begin
                lh  <= best_idx;
                lhv <= 1'b1;
                if (best_len >= req_size) begin
                  hole      <= best_idx;
                  hole_len  <= best_len;
                  hole_base <= best_base;
                  state     <= S_CARVE;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                if (pol_mod) lhv <= 1'b0;
                state <= S_DONE;
              end
            end
          end else begin
            if (idx < count) begin
              if (entries_examined != EXAM_SAT) entries_examined <= entries_examined + 1'b1;
              if (!rd_used && rd_len >= req_size) begin
                hole      <= idx[IW-1:0];
                hole_len  <= rd_len;
                hole_base <= rd_base;
                state     <= S_CARVE;
              end
              idx <= idx + 1'b1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CARVE: begin
          state <= S_DONE;
          if (hole_len == req_size) begin
            status       <= vpa_pkg::ST_OK;
            granted_base <= hole_base;
            if (entries_examined != EXAM_SAT) entries_examined <= entries_examined + 1'b1;
          end else if (count == CW'(SEGMENTS)) begin
            status <= vpa_pkg::ST_FULL;
          end else begin
            status       <= vpa_pkg::ST_OK;
            granted_base <= b_base;
            count        <= count + 1'b1;
            if (lh > hole) lh <= lh + 1'b1;
            if (entries_examined != EXAM_SAT) entries_examined <= entries_examined + 1'b1;
          end
        end
        S_FOUND: begin
          status           <= vpa_pkg::ST_OK;
          entries_examined <= EW'(1);
          state            <= S_ML;
        end
        S_ML: begin
          if (ml_merge) begin
            count <= count - 1'b1;
            if (lh >= fidx) lh <= lh - 1'b1;
            fidx <= fidx - 1'b1;
            entries_examined <= entries_examined + 1'b1;
          end
          state <= S_MR;
        end
        S_MR: begin
          if (mr_merge) begin
            count <= count - 1'b1;
            if ((CW+1)'(lh) >= fidx_p1) lh <= lh - 1'b1;
            entries_examined <= entries_examined + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // chain of segment cells
  for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
    logic [AW-1:0] lb;
    logic [LW-1:0] ll;
    logic          lu;
    logic [AW-1:0] rb;
    logic [LW-1:0] rl;
    logic          ru;
    if (g == 0) begin : g_first
      assign lb = '0;
      assign ll = '0;
      assign lu = 1'b0;
    end else begin : g_mid_l
      assign lb = c_base[g-1];
      assign ll = c_len[g-1];
      assign lu = c_used[g-1];
    end
    if (g == SEGMENTS - 1) begin : g_last
      assign rb = '0;
      assign rl = '0;
      assign ru = 1'b0;
    end else begin : g_mid_r
      assign rb = c_base[g+1];
      assign rl = c_len[g+1];
      assign ru = c_used[g+1];
    end
    vpa_cell #(
      .ME(g), .AW(AW), .CW(CW), .RESET_LEN(RESET_LEN)
    ) u_cell (
      .clk(clk), .rst(rst), .op(op), .op_idx(op_idx),
      .a_len(a_len), .b_base(b_base), .b_len(b_len), .flag(flag),
      .left_base(lb), .left_len(ll), .left_used(lu),
      .right_base(rb), .right_len(rl), .right_used(ru),
      .base(c_base[g]), .len(c_len[g]), .used(c_used[g])
    );
  end

`include "variable_partition_allocator_assert.svh"

  // checks
  `VPA_ASSERT_NOW(a_count_range, 1'b1, (count != '0) && (count <= CW'(SEGMENTS)))
  `VPA_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
  `VPA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `VPA_ASSERT_NOW(a_grant_ok, done && (granted_base != '0), status == vpa_pkg::ST_OK)

endmodule
